// ----- rtl/rc6_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc6_pkg
// Shared types, constants and word helpers for the rc6 block cipher.
// ----------------------------------------------------------------------------
package rc6_pkg;

    localparam int WORD_W    = 32;
    localparam int HALF_W    = 64;
    localparam int CFG_IDX_W = 1;

    localparam logic [WORD_W-1:0] MAGIC_P = 32'hb7e15163;
    localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9e3779b9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [HALF_W-1:0] text_low;
        logic [HALF_W-1:0] text_high;
    } text_beat_t;

    typedef struct packed {
        logic [HALF_W-1:0] out_low;
        logic [HALF_W-1:0] out_high;
    } result_beat_t;

    // round unit operations
    typedef enum logic [2:0] {
        OP_HOLD      = 3'd0,
        OP_LOAD      = 3'd1,
        OP_WHITE_IN  = 3'd2,
        OP_MIX       = 3'd3,
        OP_ROUND     = 3'd4,
        OP_WHITE_OUT = 3'd5
    } rnd_op_t;

    typedef struct packed {
        rnd_op_t op;
        logic    decrypt;
        logic    last;
    } rnd_ctrl_t;

    typedef struct packed {
        logic init;
        logic step_a;
        logic step_b;
        logic first_pass;
    } key_ctrl_t;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input logic [4:0]        n);
        logic [2*WORD_W-1:0] w;
        w = {x, x} << n;
        return w[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                                 input logic [4:0]        n);
        logic [2*WORD_W-1:0] w;
        w = {x, x} >> n;
        return w[WORD_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/rc6_key_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc6_key_unit
// Key schedule mixing step, split into a subkey half (step_a) and a key half (step_b).
// ----------------------------------------------------------------------------
module rc6_key_unit
    import rc6_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  key_ctrl_t         ctrl,
    input  logic [HALF_W-1:0] key_low,
    input  logic [HALF_W-1:0] key_high,
    input  logic [WORD_W-1:0] sk_rd,
    output logic [WORD_W-1:0] wr_data
);

    logic [WORD_W-1:0] sa_reg;
    logic [WORD_W-1:0] sb_reg;
    logic [WORD_W-1:0] init_reg;
    logic [WORD_W-1:0] kw_reg [4];
    logic [1:0]        kj_reg;

    logic [WORD_W-1:0] s_in;
    logic [WORD_W-1:0] a_new;
    logic [WORD_W-1:0] ab_sum;
    logic [WORD_W-1:0] b_new;

    always_comb
    begin
        // first pass over the table uses the arithmetic fill value
        s_in    = ctrl.first_pass ? init_reg : sk_rd;
        a_new   = rotl32(s_in + sa_reg + sb_reg, 5'd3);
        ab_sum  = sa_reg + sb_reg;
        b_new   = rotl32(kw_reg[kj_reg] + ab_sum, ab_sum[4:0]);
        wr_data = a_new;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            sa_reg    <= '0;
            sb_reg    <= '0;
            init_reg  <= MAGIC_P;
            kw_reg[0] <= key_low[WORD_W-1:0];
            kw_reg[1] <= key_low[HALF_W-1:WORD_W];
            kw_reg[2] <= key_high[WORD_W-1:0];
            kw_reg[3] <= key_high[HALF_W-1:WORD_W];
        end
        else if (ctrl.step_a)
        begin
            sa_reg   <= a_new;
            init_reg <= init_reg + MAGIC_Q;
        end
        else if (ctrl.step_b)
        begin
            sb_reg         <= b_new;
            kw_reg[kj_reg] <= b_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kj_reg <= '0;
        end
        else if (ctrl.init)
        begin
            kj_reg <= '0;
        end
        else if (ctrl.step_b)
        begin
            kj_reg <= kj_reg + 2'd1;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rc6_round_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc6_round_unit
// Shared round datapath: word registers, whitening, quadratic mix, round.
// ----------------------------------------------------------------------------
module rc6_round_unit
    import rc6_pkg::*;
(
    input  logic              clk,
    input  rnd_ctrl_t         ctrl,
    input  text_beat_t        text,
    input  logic [WORD_W-1:0] sk_even,
    input  logic [WORD_W-1:0] sk_odd,
    output result_beat_t      result
);

    logic [WORD_W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [WORD_W-1:0] a_next, b_next, c_next, d_next;
    logic [WORD_W-1:0] t_prod_reg, u_prod_reg;
    logic [WORD_W-1:0] t_word, u_word;
    logic [WORD_W-1:0] enc_a, enc_c, dec_a, dec_c;

    always_comb
    begin
        t_word = rotl32(t_prod_reg, 5'd5);
        u_word = rotl32(u_prod_reg, 5'd5);
        enc_a  = rotl32(a_reg ^ t_word, u_word[4:0]) + sk_even;
        enc_c  = rotl32(c_reg ^ u_word, t_word[4:0]) + sk_odd;
        dec_a  = rotr32(a_reg - sk_even, u_word[4:0]) ^ t_word;
        dec_c  = rotr32(c_reg - sk_odd, t_word[4:0]) ^ u_word;

        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        case (ctrl.op)
            OP_LOAD:
            begin
                a_next = text.text_low[WORD_W-1:0];
                b_next = text.text_low[HALF_W-1:WORD_W];
                c_next = text.text_high[WORD_W-1:0];
                d_next = text.text_high[HALF_W-1:WORD_W];
            end
            OP_WHITE_IN:
            begin
                if (ctrl.decrypt)
                begin
                    // whitening then the word rotation of the first round
                    a_next = d_reg;
                    b_next = a_reg - sk_even;
                    c_next = b_reg;
                    d_next = c_reg - sk_odd;
                end
                else
                begin
                    b_next = b_reg + sk_even;
                    d_next = d_reg + sk_odd;
                end
            end
            OP_ROUND:
            begin
                if (!ctrl.decrypt)
                begin
                    a_next = b_reg;
                    b_next = enc_c;
                    c_next = d_reg;
                    d_next = enc_a;
                end
                else if (ctrl.last)
                begin
                    a_next = dec_a;
                    c_next = dec_c;
                end
                else
                begin
                    a_next = d_reg;
                    b_next = dec_a;
                    c_next = b_reg;
                    d_next = dec_c;
                end
            end
            OP_WHITE_OUT:
            begin
                if (ctrl.decrypt)
                begin
                    b_next = b_reg - sk_even;
                    d_next = d_reg - sk_odd;
                end
                else
                begin
                    a_next = a_reg + sk_even;
                    c_next = c_reg + sk_odd;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        if (ctrl.op == OP_MIX)
        begin
            t_prod_reg <= b_reg * {b_reg[WORD_W-2:0], 1'b1};
            u_prod_reg <= d_reg * {d_reg[WORD_W-2:0], 1'b1};
        end
    end

    assign result.out_low  = {b_reg, a_reg};
    assign result.out_high = {d_reg, c_reg};

endmodule
`default_nettype wire

// ----- rtl/rc6_block_cipher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc6_block_cipher
// RC6-32/r/16 block cipher with an on-chip key schedule and shared round unit.
// ----------------------------------------------------------------------------
// usage
//   config: cfg_write/cfg_index/cfg_data load key_low (index 0) or key_high
//     (index 1); any write drops the schedule-ready flag; write only while idle
//   input: a beat is taken at a rising edge with start high and busy low;
//     text.cmd picks encrypt (0) or decrypt (1)
//   output: done is high for exactly one cycle with the block on result;
//     the receiver cannot hold it off and the beat is gone after that cycle
//   sequence: after the accepting edge the fsm runs a whitening state in, then
//     per round a mix state (multiply) and a round state (rotate and add), then
//     a whitening state out, and done is registered from that last state;
//     busy drops in the done cycle, so the next beat can be taken at the edge
//     that ends it; no new block is taken while one is in progress
//   key change: the first block after a key write first runs the schedule,
//     each mixing step a subkey half (step_a) then a key half (step_b)
//   subkeys live in a one-write, two-read table with registered read data
//   reset: the flag clears, the fsm idles, the key registers read zero
// ----------------------------------------------------------------------------
module rc6_block_cipher
    import rc6_pkg::*;
#(
    parameter int NUM_ROUNDS = 20
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0]    cfg_data,
    input  logic                 start,
    input  text_beat_t           text,
    output logic                 busy,
    output logic                 done,
    output result_beat_t         result
);

    localparam int TABLE_WORDS = 2 * NUM_ROUNDS + 4;
    localparam int ADDR_W      = $clog2(TABLE_WORDS);
    localparam int STEP_W      = $clog2(3 * TABLE_WORDS);
    localparam int RND_W       = $clog2(NUM_ROUNDS + 1);

    localparam logic [ADDR_W-1:0] HEAD_ADDR  = '0;
    localparam logic [ADDR_W-1:0] TAIL_ADDR  = ADDR_W'(2 * NUM_ROUNDS + 2);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(TABLE_WORDS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(3 * TABLE_WORDS - 1);
    localparam logic [STEP_W-1:0] PASS_STEPS = STEP_W'(TABLE_WORDS);
    localparam logic [RND_W-1:0]  FIRST_RND  = RND_W'(1);
    localparam logic [RND_W-1:0]  FINAL_RND  = RND_W'(NUM_ROUNDS);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_KEY_A     = 7'b0000010,
        ST_KEY_B     = 7'b0000100,
        ST_WHITE_IN  = 7'b0001000,
        ST_MIX       = 7'b0010000,
        ST_ROUND     = 7'b0100000,
        ST_WHITE_OUT = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic              ready_reg, ready_next;
    logic              cmd_reg, cmd_next;
    logic              done_reg, done_next;
    logic [ADDR_W-1:0] si_reg, si_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [HALF_W-1:0] key_low_reg, key_high_reg;

    // subkey table, undefined until the schedule has written it
    logic [WORD_W-1:0] subkey_mem [TABLE_WORDS];
    logic [WORD_W-1:0] rd0_reg, rd1_reg;
    logic [ADDR_W-1:0] rd_addr0, rd_addr1;
    logic              mem_we;
    logic [WORD_W-1:0] key_wr_data;

    rnd_ctrl_t rnd_ctrl;
    key_ctrl_t key_ctrl;
    logic      last_round;
    logic      si_wrap;

    // the last round differs by direction of count
    assign last_round = cmd_reg ? (rnd_reg == FIRST_RND) : (rnd_reg == FINAL_RND);
    assign si_wrap    = (si_reg == LAST_ADDR);

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd_next   = cmd_reg;
        si_next    = si_reg;
        step_next  = step_reg;
        rnd_next   = rnd_reg;
        done_next  = 1'b0;
        mem_we     = 1'b0;
        rd_addr0   = HEAD_ADDR;

        rnd_ctrl.op      = OP_HOLD;
        rnd_ctrl.decrypt = cmd_reg;
        rnd_ctrl.last    = last_round;

        key_ctrl.init       = 1'b0;
        key_ctrl.step_a     = 1'b0;
        key_ctrl.step_b     = 1'b0;
        key_ctrl.first_pass = (step_reg < PASS_STEPS);

        unique case (state_reg)
            ST_IDLE:
            begin
                // fetch whitening keys ahead in case the schedule is valid
                rd_addr0 = text.cmd ? TAIL_ADDR : HEAD_ADDR;
                if (start)
                begin
                    cmd_next    = text.cmd;
                    rnd_ctrl.op = OP_LOAD;
                    if (ready_reg)
                    begin
                        state_next = ST_WHITE_IN;
                    end
                    else
                    begin
                        key_ctrl.init = 1'b1;
                        si_next       = '0;
                        step_next     = '0;
                        state_next    = ST_KEY_A;
                    end
                end
            end
            ST_KEY_A:
            begin
                key_ctrl.step_a = 1'b1;
                mem_we          = 1'b1;
                state_next      = ST_KEY_B;
            end
            ST_KEY_B:
            begin
                key_ctrl.step_b = 1'b1;
                si_next         = si_wrap ? '0 : si_reg + ADDR_W'(1);
                step_next       = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    ready_next = 1'b1;
                    rd_addr0   = cmd_reg ? TAIL_ADDR : HEAD_ADDR;
                    state_next = ST_WHITE_IN;
                end
                else
                begin
                    // prefetch the subkey for the next mixing step
                    rd_addr0   = si_wrap ? '0 : si_reg + ADDR_W'(1);
                    state_next = ST_KEY_A;
                end
            end
            ST_WHITE_IN:
            begin
                rnd_ctrl.op = OP_WHITE_IN;
                rnd_next    = cmd_reg ? FINAL_RND : FIRST_RND;
                state_next  = ST_MIX;
            end
            ST_MIX:
            begin
                rnd_ctrl.op = OP_MIX;
                rd_addr0    = ADDR_W'({rnd_reg, 1'b0});
                state_next  = ST_ROUND;
            end
            ST_ROUND:
            begin
                rnd_ctrl.op = OP_ROUND;
                if (last_round)
                begin
                    rd_addr0   = cmd_reg ? HEAD_ADDR : TAIL_ADDR;
                    state_next = ST_WHITE_OUT;
                end
                else
                begin
                    rnd_next   = cmd_reg ? rnd_reg - RND_W'(1) : rnd_reg + RND_W'(1);
                    state_next = ST_MIX;
                end
            end
            ST_WHITE_OUT:
            begin
                rnd_ctrl.op = OP_WHITE_OUT;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // any key write forces a fresh schedule
        if (cfg_write)
        begin
            ready_next = 1'b0;
        end
    end

    // odd partner of an even pair; key reads only use port 0
    assign rd_addr1 = rd_addr0 | ADDR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
            cmd_reg   <= 1'b0;
            done_reg  <= 1'b0;
            si_reg    <= '0;
            step_reg  <= '0;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            cmd_reg   <= cmd_next;
            done_reg  <= done_next;
            si_reg    <= si_next;
            step_reg  <= step_next;
            rnd_reg   <= rnd_next;
        end
    end

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // subkey table: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            subkey_mem[si_reg] <= key_wr_data;
        end
        rd0_reg <= subkey_mem[rd_addr0];
        rd1_reg <= subkey_mem[rd_addr1];
    end

    rc6_key_unit u_key_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (key_ctrl),
        .key_low  (key_low_reg),
        .key_high (key_high_reg),
        .sk_rd    (rd0_reg),
        .wr_data  (key_wr_data)
    );

    rc6_round_unit u_round_unit (
        .clk     (clk),
        .ctrl    (rnd_ctrl),
        .text    (text),
        .sk_even (rd0_reg),
        .sk_odd  (rd1_reg),
        .result  (result)
    );

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire

// ----- rtl/rc6_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc6_checker
// Port-level checks of the start/busy/done sequencing of the cipher.
// ----------------------------------------------------------------------------
module rc6_checker
(
    input wire clk,
    input wire rst_n,
    input wire start,
    input wire busy,
    input wire done
);

    // an accepted beat makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("rc6: accepted beat did not raise busy");

    // a result beat lasts one cycle only
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("rc6: done held for more than one cycle");

    // a result beat comes exactly when work finishes
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $fell(busy))
        else $error("rc6: done without end of work");

    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("rc6: work ended without a result beat");

    // no result beat out of an idle cycle
    assert property (@(posedge clk) disable iff (!rst_n) !busy |=> !done)
        else $error("rc6: done while idle");

endmodule

bind rc6_block_cipher rc6_checker u_rc6_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rc6 block cipher. A scoreboard class carries its
// own key schedule and round arithmetic, predicts every block from the key
// registers last written, and compares each done beat field by field.
// Stimulus: short directed sets under the reset and all-ones keys, bursty random
// blocks with round trips (decrypting the last result) mixed in, across several keys.
// ----------------------------------------------------------------------------
module tb_top;
    import rc6_pkg::*;

    localparam int NUM_ROUNDS   = 20;
    localparam int TABLE_W      = 2 * NUM_ROUNDS + 4;
    // longest quiet stretch in a good run: schedule, block and sender gap together
    localparam int STALL_LIMIT  = 4000;
    // cycles left to run once nothing is outstanding, to catch stray done beats
    localparam int FLUSH_CYCLES = 2 * NUM_ROUNDS + 20;

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    localparam logic [HALF_W-1:0] ALL_ONES = {HALF_W{1'b1}};

    // ------------------------------------------------------------------------
    // scoreboard: key registers, subkey table, expected result beats
    // ------------------------------------------------------------------------
    class rc6_scoreboard;
        logic [HALF_W-1:0] key_reg [2];
        logic [WORD_W-1:0] subkey [TABLE_W];
        bit                keys_ready;
        result_beat_t      expected_q [$];
        result_beat_t      last_out;
        logic              last_cmd;
        int                errors;

        function new();
            key_reg[0] = '0;
            key_reg[1] = '0;
            keys_ready = 1'b0;
            last_out   = '0;
            last_cmd   = CMD_ENC;
            errors     = 0;
        endfunction

        function logic [WORD_W-1:0] rotl_word(logic [WORD_W-1:0] x,
                                              logic [WORD_W-1:0] n);
            int unsigned s;
            s = n % WORD_W;
            if (s == 0)
                return x;
            return (x << s) | (x >> (WORD_W - s));
        endfunction

        function logic [WORD_W-1:0] rotr_word(logic [WORD_W-1:0] x,
                                              logic [WORD_W-1:0] n);
            int unsigned s;
            s = n % WORD_W;
            if (s == 0)
                return x;
            return (x >> s) | (x << (WORD_W - s));
        endfunction

        // x * (2x + 1), rotated left by five
        function logic [WORD_W-1:0] mix_word(logic [WORD_W-1:0] x);
            logic [WORD_W-1:0] prod;
            prod = x * ((x << 1) + 1);
            return rotl_word(prod, 5);
        endfunction

        function void note_key_write(logic [CFG_IDX_W-1:0] idx,
                                     logic [HALF_W-1:0]    data);
            key_reg[idx] = data;
            keys_ready   = 1'b0;
        endfunction

        function void expand_key();
            logic [WORD_W-1:0] kw [4];
            logic [WORD_W-1:0] a;
            logic [WORD_W-1:0] b;
            int                si;
            int                kj;
            kw[0] = key_reg[REG_KEY_LOW][31:0];
            kw[1] = key_reg[REG_KEY_LOW][63:32];
            kw[2] = key_reg[REG_KEY_HIGH][31:0];
            kw[3] = key_reg[REG_KEY_HIGH][63:32];
            subkey[0] = MAGIC_P;
            for (int n = 1; n < TABLE_W; n++)
                subkey[n] = subkey[n-1] + MAGIC_Q;
            a  = '0;
            b  = '0;
            si = 0;
            kj = 0;
            for (int n = 0; n < 3 * TABLE_W; n++)
            begin
                a          = rotl_word(subkey[si] + a + b, 3);
                subkey[si] = a;
                b          = rotl_word(kw[kj] + a + b, a + b);
                kw[kj]     = b;
                si         = (si + 1) % TABLE_W;
                kj         = (kj + 1) % 4;
            end
            keys_ready = 1'b1;
        endfunction

        // works out the block's result and queues it
        function void note_block(text_beat_t beat);
            logic [WORD_W-1:0] a, bw, c, d, t, u, tmp;
            result_beat_t      res;
            if (!keys_ready)
                expand_key();
            a  = beat.text_low[31:0];
            bw = beat.text_low[63:32];
            c  = beat.text_high[31:0];
            d  = beat.text_high[63:32];
            if (beat.cmd == CMD_ENC)
            begin
                bw = bw + subkey[0];
                d  = d + subkey[1];
                for (int rnd = 1; rnd <= NUM_ROUNDS; rnd++)
                begin
                    t   = mix_word(bw);
                    u   = mix_word(d);
                    a   = rotl_word(a ^ t, u) + subkey[2*rnd];
                    c   = rotl_word(c ^ u, t) + subkey[2*rnd+1];
                    tmp = a;
                    a   = bw;
                    bw  = c;
                    c   = d;
                    d   = tmp;
                end
                a = a + subkey[2*NUM_ROUNDS+2];
                c = c + subkey[2*NUM_ROUNDS+3];
            end
            else
            begin
                a = a - subkey[2*NUM_ROUNDS+2];
                c = c - subkey[2*NUM_ROUNDS+3];
                for (int rnd = NUM_ROUNDS; rnd >= 1; rnd--)
                begin
                    tmp = d;
                    d   = c;
                    c   = bw;
                    bw  = a;
                    a   = tmp;
                    t   = mix_word(bw);
                    u   = mix_word(d);
                    c   = rotr_word(c - subkey[2*rnd+1], t) ^ u;
                    a   = rotr_word(a - subkey[2*rnd], u) ^ t;
                end
                bw = bw - subkey[0];
                d  = d - subkey[1];
            end
            res.out_low  = {bw, a};
            res.out_high = {d, c};
            expected_q.push_back(res);
            last_out = res;
            last_cmd = beat.cmd;
        endfunction

        function void check_result(result_beat_t got);
            result_beat_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: out_low %h out_high %h",
                         $time, got.out_low, got.out_high);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_low !== want.out_low)
            begin
                $display("%0t: out_low mismatch: expected %h, actual %h",
                         $time, want.out_low, got.out_low);
                errors++;
            end
            if (got.out_high !== want.out_high)
            begin
                $display("%0t: out_high mismatch: expected %h, actual %h",
                         $time, want.out_high, got.out_high);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HALF_W-1:0]    cfg_data;
    logic                 start;
    text_beat_t           text;
    logic                 busy;
    logic                 done;
    result_beat_t         result;

    rc6_scoreboard sb;
    int            idle_cycles = 0;

    rc6_block_cipher #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .text      (text),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

    always #6 clk = ~clk;

    // done is a one-cycle strobe and cannot be held off, so every rising edge
    // with done high carries a result beat
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // watchdog: any accepted beat, in or out, resets the count
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driving tasks: each one is entered just after a falling edge and returns
    // just after a falling edge; start is left high by send_block, so the
    // caller always follows with another send_block or with hold_off
    // ------------------------------------------------------------------------
    function automatic text_beat_t block_of(logic cmd, logic [HALF_W-1:0] lo,
                                            logic [HALF_W-1:0] hi);
        text_beat_t beat;
        beat.cmd       = cmd;
        beat.text_low  = lo;
        beat.text_high = hi;
        return beat;
    endfunction

    // presents a block and holds it until the edge that takes it
    task automatic send_block(input text_beat_t beat);
        start <= 1'b1;
        text  <= beat;
        do
            @(posedge clk);
        while (busy);
        sb.note_block(beat);
        @(negedge clk);
    endtask

    // sender gap; text carries junk while start is low
    task automatic hold_off(input int cycles);
        text_beat_t junk;
        junk.cmd       = 1'($urandom_range(0, 1));
        junk.text_low  = {$urandom, $urandom};
        junk.text_high = {$urandom, $urandom};
        start <= 1'b0;
        text  <= junk;
        repeat (cycles) @(negedge clk);
    endtask

    // waits until every predicted beat has come back and the block is idle
    task automatic drain_results();
        while (sb.pending() != 0 || busy)
            @(negedge clk);
    endtask

    // key writes only ever happen after drain_results
    task automatic write_key(input logic [CFG_IDX_W-1:0] idx,
                             input logic [HALF_W-1:0]    data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.note_key_write(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_data  <= {$urandom, $urandom};
        @(negedge clk);
    endtask

    // random block: free data half the time, with round trips that undo the last
    // result, plus the all-zero, all-one and single-bit corners
    function automatic text_beat_t make_block();
        text_beat_t beat;
        int         pick;
        pick           = $urandom_range(0, 9);
        beat.cmd       = 1'($urandom_range(0, 1));
        beat.text_low  = {$urandom, $urandom};
        beat.text_high = {$urandom, $urandom};
        if (pick < 3)
        begin
            beat.cmd       = ~sb.last_cmd;
            beat.text_low  = sb.last_out.out_low;
            beat.text_high = sb.last_out.out_high;
        end
        else if (pick == 3)
        begin
            beat.text_low  = $urandom_range(0, 1) ? ALL_ONES : '0;
            beat.text_high = $urandom_range(0, 1) ? ALL_ONES : '0;
        end
        else if (pick == 4)
        begin
            beat.text_low  = 64'd1 << $urandom_range(0, 63);
            beat.text_high = 64'd1 << $urandom_range(0, 63);
        end
        return beat;
    endfunction

    // bursts of random length; long bursts keep start high across several
    // blocks, gaps of varying length land on every phase of the round count
    task automatic run_random(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 3) == 0)
                burst = $urandom_range(12, 40);
            else
                burst = $urandom_range(1, 6);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                send_block(make_block());
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(30, 90);
            else
                gap = $urandom_range(1, 12);
            hold_off(gap);
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [HALF_W-1:0] keep_high;
        sb        = new();
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_KEY_LOW;
        cfg_data  = '0;
        start     = 1'b0;
        text      = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // key left at its reset value: the schedule must still run first
        send_block(block_of(CMD_ENC, '0, '0));
        send_block(block_of(CMD_ENC, ALL_ONES, ALL_ONES));
        send_block(block_of(CMD_DEC, '0, '0));
        send_block(block_of(CMD_DEC, ALL_ONES, ALL_ONES));
        send_block(block_of(CMD_ENC, 64'h0000_0000_ffff_ffff, '0));
        send_block(block_of(CMD_ENC, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555));
        // decrypting the last ciphertext has to give the plaintext back
        send_block(block_of(CMD_DEC, sb.last_out.out_low, sb.last_out.out_high));
        send_block(block_of(CMD_ENC, 64'h8000_0000_0000_0000, 64'd1));
        hold_off(1);
        drain_results();

        // all-ones key
        write_key(REG_KEY_LOW, ALL_ONES);
        write_key(REG_KEY_HIGH, ALL_ONES);
        send_block(block_of(CMD_ENC, '0, '0));
        send_block(block_of(CMD_DEC, ALL_ONES, ALL_ONES));
        send_block(block_of(CMD_ENC, {$urandom, $urandom}, {$urandom, $urandom}));
        send_block(block_of(CMD_DEC, sb.last_out.out_low, sb.last_out.out_high));
        hold_off(1);
        run_random(200);
        drain_results();

        // explicit all-zero key
        write_key(REG_KEY_LOW, '0);
        write_key(REG_KEY_HIGH, '0);
        run_random(200);
        drain_results();

        // random key; the sender stops halfway until every beat is back
        write_key(REG_KEY_LOW, {$urandom, $urandom});
        write_key(REG_KEY_HIGH, {$urandom, $urandom});
        run_random(150);
        drain_results();
        run_random(150);
        drain_results();

        // same value written again still forces a fresh schedule
        keep_high = sb.key_reg[REG_KEY_HIGH];
        write_key(REG_KEY_HIGH, keep_high);
        run_random(200);
        drain_results();

        // only the low half changes
        write_key(REG_KEY_LOW, {$urandom, $urandom});
        run_random(200);
        drain_results();

        // another random key, high half first
        write_key(REG_KEY_HIGH, {$urandom, $urandom});
        write_key(REG_KEY_LOW, {$urandom, $urandom});
        run_random(390);
        drain_results();

        // let any stray done beat show up before deciding
        repeat (FLUSH_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rc6_pkg.sv
rtl/rc6_key_unit.sv
rtl/rc6_round_unit.sv
rtl/rc6_block_cipher.sv
rtl/rc6_checker.sv
tb/tb_top.sv
